@@ rtl/core/bracket_balance_checker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Bracket balance checker - assertion macros
// Shared property shapes for the checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker - package
// Stack sizing, bracket codes and byte classification helpers.
// ----------------------------------------------------------------------------
package bbc_pkg;

	// Stack sizing
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Codes held on the stack for each kind of opening bracket
	typedef enum logic [1:0] {
		BR_NONE   = 2'd0,
		BR_ROUND  = 2'd1,
		BR_SQUARE = 2'd2,
		BR_CURLY  = 2'd3
	} bracket_t;

	// ASCII codes of the brackets
	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }

	// Kind of opening bracket, BR_NONE for any other byte
	function automatic bracket_t opener_code(input logic [7:0] c);
		bracket_t r;
		case (c)
			CH_OPEN_ROUND:  r = BR_ROUND;
			CH_OPEN_SQUARE: r = BR_SQUARE;
			CH_OPEN_CURLY:  r = BR_CURLY;
			default:        r = BR_NONE;
		endcase
		return r;
	endfunction

	// Kind of opening bracket that a closing bracket needs, BR_NONE otherwise
	function automatic bracket_t closer_code(input logic [7:0] c);
		bracket_t r;
		case (c)
			CH_CLOSE_ROUND:  r = BR_ROUND;
			CH_CLOSE_SQUARE: r = BR_SQUARE;
			CH_CLOSE_CURLY:  r = BR_CURLY;
			default:         r = BR_NONE;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/bracket_balance_checker_unit.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker unit
// Streams a string a byte per word and reports whether (), [] and {} nest.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, one word per byte (char_code), with
// has_char clear for an end word that carries no byte and end_of_string set
// on the last word of a string. Non-bracket bytes only mark the string as
// non-empty. Output channel: out_valid / out_stall, one result word
// (balanced, stack_overflow) per string, taken from its last input word.
// Throughput: one input word per cycle while in_stall is low. Each word does
// at most one push or pop; the top entry lives in a register and the entry
// under it is kept prefetched from the stack memory (synchronous read), so
// consecutive pops need no bubble. A string's result is registered into the
// output register, or into the skid stage while the output register stalls.
// Receiver stall: the output register is backed by a one-word skid stage, so
// input words keep flowing while a result waits; in_stall rises only once
// the skid stage holds a result, the second one waiting.
// Reset: arst_n clears the count and the sticky flags and empties both output
// stages; the stack memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_unit_defines.svh"

module bracket_balance_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       has_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       balanced,
	output logic       stack_overflow
);

	// Stack storage and control state
	bbc_pkg::bracket_t                 stack_mem_q [bbc_pkg::STACK_DEPTH];
	bbc_pkg::bracket_t                 tos_q;
	bbc_pkg::bracket_t                 under_q;
	logic [bbc_pkg::CNT_W-1:0]         count_q;
	logic                              fail_q;
	logic                              ovf_q;
	logic                              seen_q;

	// Output register and skid stage
	logic                              out_valid_q;
	logic                              out_bal_q;
	logic                              out_ovf_q;
	logic                              skid_valid_q;
	logic                              skid_bal_q;
	logic                              skid_ovf_q;

	logic                              accept;
	logic                              res_valid;
	logic                              res_bal;
	logic                              out_pop;
	bbc_pkg::bracket_t                 open_c;
	bbc_pkg::bracket_t                 close_c;
	logic                              do_push;
	logic                              do_pop;
	logic [bbc_pkg::CNT_W-1:0]         count_n;
	logic [bbc_pkg::CNT_W-1:0]         count_d;
	logic                              fail_n;
	logic                              ovf_n;
	logic                              seen_n;
	logic [bbc_pkg::ADDR_W-1:0]        rd_addr;
	logic [bbc_pkg::ADDR_W-1:0]        wr_addr;

	assign accept  = in_valid && !in_stall;
	assign out_pop = out_valid_q && !out_stall;

	// Byte classification and push/pop decision
	always_comb begin
		open_c  = bbc_pkg::opener_code(char_code);
		close_c = bbc_pkg::closer_code(char_code);
		do_push = 1'b0;
		do_pop  = 1'b0;
		count_n = count_q;
		fail_n  = fail_q;
		ovf_n   = ovf_q;
		seen_n  = seen_q;
		if (has_char) begin
			seen_n = 1'b1;
			if (!fail_q) begin
				if (open_c != bbc_pkg::BR_NONE) begin
					if (count_q == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
						fail_n = 1'b1;
						ovf_n  = 1'b1;
					end else begin
						do_push = 1'b1;
						count_n = count_q + bbc_pkg::CNT_W'(1);
					end
				end else if (close_c != bbc_pkg::BR_NONE) begin
					if (count_q == '0 || tos_q != close_c) begin
						fail_n = 1'b1;
					end else begin
						do_pop  = 1'b1;
						count_n = count_q - bbc_pkg::CNT_W'(1);
					end
				end
			end
		end
		res_valid = accept && end_of_string;
		res_bal   = seen_n && !fail_n && (count_n == '0);
		// count after this word, with the string end clearing it
		count_d   = !accept ? count_q : (end_of_string ? '0 : count_n);
	end

	function automatic logic [bbc_pkg::ADDR_W-1:0] ADDR_SEL(
		input logic [bbc_pkg::CNT_W-1:0] cnt
	);
		logic [bbc_pkg::CNT_W-1:0] a;
		a = cnt - bbc_pkg::CNT_W'(2);
		return a[bbc_pkg::ADDR_W-1:0];
	endfunction

	// Push writes the new top at the old count; the prefetch reads the entry
	// under the next top. A push reads one below its write, so the two ports
	// never meet on the same entry.
	assign wr_addr = count_q[bbc_pkg::ADDR_W-1:0];
	assign rd_addr = ADDR_SEL(count_d);

	// Stack memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			stack_mem_q[wr_addr] <= open_c;
		end
		under_q <= stack_mem_q[rd_addr];
	end

	// Top of stack register
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			tos_q <= open_c;
		end else if (accept && do_pop) begin
			tos_q <= under_q;
		end
	end

	// Count and sticky flags, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fail_q  <= 1'b0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			fail_q  <= end_of_string ? 1'b0 : fail_n;
			ovf_q   <= end_of_string ? 1'b0 : ovf_n;
			seen_q  <= end_of_string ? 1'b0 : seen_n;
		end
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_pop) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_bal_q <= skid_bal_q;
				out_ovf_q <= skid_ovf_q;
			end
		end else if (!out_valid_q || out_pop) begin
			out_bal_q <= res_bal;
			out_ovf_q <= ovf_n;
		end else if (res_valid) begin
			skid_bal_q <= res_bal;
			skid_ovf_q <= ovf_n;
		end
	end

	assign in_stall       = skid_valid_q;
	assign out_valid      = out_valid_q;
	assign balanced       = out_bal_q;
	assign stack_overflow = out_ovf_q;

	// Checks
	`BBC_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1,
		count_q <= bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH), "stack count above depth")
	`BBC_ASSERT_SAME(a_ovf_fails, clk, arst_n, ovf_q, fail_q,
		"overflow flagged without failure")
	`BBC_ASSERT_NEXT(a_end_clears, clk, arst_n, accept && end_of_string,
		count_q == '0 && !fail_q && !seen_q, "string state not cleared at end")
	`BBC_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q,
		"skid stage holds a word while output register is empty")

endmodule

@@ sim/bracket_balance_checker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker unit - testbench
// Streams strings a word per byte through the checker and compares every
// result word with a bracket-nesting predictor or a typed-in result. A short
// table of directed strings covers empty strings, end words with and without
// a byte, mismatches, a full stack and an overflow. Random strings follow,
// mostly well nested with noise, plus broken and pure noise strings, under
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected result word
	typedef struct packed {
		logic bal;
		logic ovf;
	} verdict_t;

	// One directed row: byte, flags, repeat count and typed-in result
	typedef struct packed {
		logic [7:0]  c;
		logic        h;
		logic        e;
		logic [15:0] rep;
		logic        typed;
		logic        bal;
		logic        ovf;
	} script_row_t;

	localparam int N_ROWS    = 22;
	localparam int HOLD_CYC  = 300;
	localparam int N_RANDOM  = 1400;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic [7:0] char_code      = 8'h00;
	logic       has_char       = 1'b0;
	logic       end_of_string  = 1'b0;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic       balanced;
	logic       stack_overflow;

	verdict_t   pending_verdicts[$];
	int         error_count = 0;
	int         words_sent  = 0;
	bit         no_gaps     = 1'b0;
	bit         hold_rx     = 1'b0;

	// Predictor state for the string in flight
	bbc_pkg::bracket_t nest_stack[bbc_pkg::STACK_DEPTH];
	int unsigned       nest_depth   = 0;
	bit                str_failed   = 1'b0;
	bit                str_overflow = 1'b0;
	bit                str_seen     = 1'b0;

	// Directed strings; a result is typed in only where it is obvious
	script_row_t script[N_ROWS] = '{
		// empty string
		'{8'h00, 1'b0, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0},
		// a lone letter is balanced
		'{8'h41, 1'b1, 1'b1, 16'd1, 1'b1, 1'b1, 1'b0},
		// every bracket, ending on a byte
		'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_OPEN_CURLY,   1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_CURLY,  1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_ROUND,  1'b1, 1'b1, 16'd1, 1'b1, 1'b1, 1'b0},
		// closer on an empty stack
		'{bbc_pkg::CH_CLOSE_ROUND,  1'b1, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0},
		// mismatch, then bytes after the failure, then a bare end word
		'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_OPEN_CURLY,   1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{8'hFF,                    1'b0, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0},
		// top byte value, a word without a byte, bottom byte value
		'{8'hFF,                    1'b1, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_OPEN_ROUND,   1'b0, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
		'{8'h00,                    1'b1, 1'b1, 16'd1, 1'b0, 1'b0, 1'b0},
		// stack filled to the brim and emptied again
		'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0, 16'(bbc_pkg::STACK_DEPTH),
			1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b1, 16'(bbc_pkg::STACK_DEPTH),
			1'b1, 1'b1, 1'b0},
		// one push past full
		'{bbc_pkg::CH_OPEN_CURLY,   1'b1, 1'b0, 16'(bbc_pkg::STACK_DEPTH + 1),
			1'b0, 1'b0, 1'b0},
		'{bbc_pkg::CH_CLOSE_CURLY,  1'b1, 1'b1, 16'd2, 1'b1, 1'b0, 1'b1},
		// flags cleared; an unclosed opener fails
		'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0},
		'{8'h80,                    1'b1, 1'b1, 16'd1, 1'b0, 1'b0, 1'b0}
	};

	bracket_balance_checker_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.has_char       (has_char),
		.end_of_string  (end_of_string),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.balanced       (balanced),
		.stack_overflow (stack_overflow)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Mismatch report: one line, one count
	task automatic flag_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		error_count++;
	endtask

	function automatic logic [7:0] open_char(input bbc_pkg::bracket_t k);
		case (k)
			bbc_pkg::BR_ROUND:  return bbc_pkg::CH_OPEN_ROUND;
			bbc_pkg::BR_SQUARE: return bbc_pkg::CH_OPEN_SQUARE;
			default:            return bbc_pkg::CH_OPEN_CURLY;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input bbc_pkg::bracket_t k);
		case (k)
			bbc_pkg::BR_ROUND:  return bbc_pkg::CH_CLOSE_ROUND;
			bbc_pkg::BR_SQUARE: return bbc_pkg::CH_CLOSE_SQUARE;
			default:            return bbc_pkg::CH_CLOSE_CURLY;
		endcase
	endfunction

	// Nesting predictor: advances the string state by one word and gives
	// the result word when the string ends
	task automatic nest_predict(input logic [7:0] c, input bit h, input bit e,
			output bit got, output verdict_t v);
		bbc_pkg::bracket_t op;
		bbc_pkg::bracket_t cl;
		op  = bbc_pkg::BR_NONE;
		cl  = bbc_pkg::BR_NONE;
		got = 1'b0;
		v   = '0;
		case (c)
			bbc_pkg::CH_OPEN_ROUND:   op = bbc_pkg::BR_ROUND;
			bbc_pkg::CH_OPEN_SQUARE:  op = bbc_pkg::BR_SQUARE;
			bbc_pkg::CH_OPEN_CURLY:   op = bbc_pkg::BR_CURLY;
			bbc_pkg::CH_CLOSE_ROUND:  cl = bbc_pkg::BR_ROUND;
			bbc_pkg::CH_CLOSE_SQUARE: cl = bbc_pkg::BR_SQUARE;
			bbc_pkg::CH_CLOSE_CURLY:  cl = bbc_pkg::BR_CURLY;
			default: ;
		endcase
		if (h) begin
			str_seen = 1'b1;
			if (!str_failed) begin
				if (op != bbc_pkg::BR_NONE) begin
					if (nest_depth == bbc_pkg::STACK_DEPTH) begin
						str_failed   = 1'b1;
						str_overflow = 1'b1;
					end else begin
						nest_stack[nest_depth] = op;
						nest_depth++;
					end
				end else if (cl != bbc_pkg::BR_NONE) begin
					if (nest_depth == 0 || nest_stack[nest_depth - 1] != cl)
						str_failed = 1'b1;
					else
						nest_depth--;
				end
			end
		end
		if (e) begin
			got   = 1'b1;
			v.bal = str_seen && !str_failed && nest_depth == 0;
			v.ovf = str_overflow;
			nest_depth   = 0;
			str_failed   = 1'b0;
			str_overflow = 1'b0;
			str_seen     = 1'b0;
		end
	endtask

	// Offer one word, wait for it to be taken, then maybe leave a gap.
	// Valid stays high after acceptance only when the next word follows at once.
	task automatic send_word(input logic [7:0] c, input bit h, input bit e,
			input bit typed, input verdict_t tv);
		int       gap;
		int       x;
		bit       got;
		verdict_t v;
		in_valid      <= 1'b1;
		char_code     <= c;
		has_char      <= h;
		end_of_string <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		nest_predict(c, h, e, got, v);
		if (got)
			pending_verdicts.push_back(typed ? tv : v);
		words_sent++;
		// trailing gap: mostly none or short, now and then long
		x = $urandom_range(0, 99);
		if (no_gaps || x < 55)
			gap = 0;
		else if (x < 88)
			gap = $urandom_range(1, 3);
		else if (x < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// One random string: mostly well nested with noise, some broken, some noise
	task automatic send_random_string();
		logic [7:0]        body[$];
		bbc_pkg::bracket_t open_q[$];
		bbc_pkg::bracket_t k;
		int                style;
		int                deep;
		int                len;
		int                r;
		int                pos;
		logic [7:0]        noise;
		style = $urandom_range(0, 99);
		deep  = ($urandom_range(0, 39) == 0)
			? bbc_pkg::STACK_DEPTH - 1 + $urandom_range(0, 3)
			: $urandom_range(1, 8);
		len   = $urandom_range(0, 14);
		if (style >= 90) begin
			repeat (len) body.push_back(8'($urandom_range(0, 255)));
		end else begin
			// deep strings start with a run of openers
			if (deep > 8) begin
				repeat (deep) begin
					k = bbc_pkg::bracket_t'($urandom_range(1, 3));
					open_q.push_back(k);
					body.push_back(open_char(k));
				end
			end
			repeat (len) begin
				r     = $urandom_range(0, 9);
				noise = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(8'h61, 8'h7A));
				if (r < 4 && open_q.size() < deep) begin
					k = bbc_pkg::bracket_t'($urandom_range(1, 3));
					open_q.push_back(k);
					body.push_back(open_char(k));
				end else if (r < 8 && open_q.size() > 0) begin
					body.push_back(close_char(open_q.pop_back()));
				end else begin
					body.push_back(noise);
				end
			end
			while (open_q.size() > 0)
				body.push_back(close_char(open_q.pop_back()));
			// broken strings: one byte replaced by a bracket or one byte dropped
			if (style >= 70 && body.size() > 0) begin
				pos = $urandom_range(0, body.size() - 1);
				k   = bbc_pkg::bracket_t'($urandom_range(1, 3));
				case ($urandom_range(0, 2))
					0: body[pos] = open_char(k);
					1: body[pos] = close_char(k);
					default: body.delete(pos);
				endcase
			end
		end
		// end either on the last byte or on a bare end word
		if (body.size() > 0 && $urandom_range(0, 1)) begin
			foreach (body[i]) begin
				if ($urandom_range(0, 9) == 0)
					send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
				send_word(body[i], 1'b1, i == body.size() - 1, 1'b0, '0);
			end
		end else begin
			foreach (body[i]) begin
				if ($urandom_range(0, 9) == 0)
					send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
				send_word(body[i], 1'b1, 1'b0, 1'b0, '0);
			end
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
		end
	endtask

	// Receiver holds off for a long stretch while short strings pour in,
	// the sender keeps offering until the hold has ended
	task automatic pressure_burst();
		hold_rx = 1'b1;
		no_gaps = 1'b1;
		do
			send_random_string();
		while (hold_rx);
		no_gaps = 1'b0;
	endtask

	// Output side: random stalls, long quiet runs, and the long hold on request
	initial begin
		int x;
		int s;
		int r;
		wait (arst_n);
		forever begin
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				hold_rx = 1'b0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				x = $urandom_range(0, 99);
				if (x < 55)
					s = 0;
				else if (x < 90)
					s = $urandom_range(1, 4);
				else if (x < 97)
					s = $urandom_range(5, 15);
				else
					s = $urandom_range(30, 80);
				r = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
					: $urandom_range(1, 6);
				if (s > 0) begin
					out_stall <= 1'b1;
					repeat (s) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (r) @(posedge clk);
			end
		end
	end

	// Result checker: each taken word against the oldest expectation
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch($sformatf("result word (bal %b ovf %b) with nothing pending",
					balanced, stack_overflow));
			end else begin
				v = pending_verdicts.pop_front();
				if (balanced !== v.bal)
					flag_mismatch($sformatf("balanced %b, expected %b", balanced, v.bal));
				if (stack_overflow !== v.ovf)
					flag_mismatch($sformatf("stack_overflow %b, expected %b",
						stack_overflow, v.ovf));
			end
		end
	end

	// Stimulus
	initial begin
		int base;
		verdict_t tv;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (script[i]) begin
			tv = '{bal: script[i].bal, ovf: script[i].ovf};
			for (int k = 0; k < script[i].rep; k++)
				send_word(script[i].c, script[i].h, script[i].e && k == script[i].rep - 1,
					script[i].typed, tv);
		end
		hold_input();
		drain();

		// random strings, each half opened by a fill-up, with a full pause midway
		base = words_sent;
		pressure_burst();
		while (words_sent < base + N_RANDOM / 2)
			send_random_string();
		hold_input();
		drain();
		pressure_burst();
		while (words_sent < base + N_RANDOM)
			send_random_string();
		hold_input();

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("bracket_balance_checker_unit_tb: done, clean");
		else
			$display("bracket_balance_checker_unit_tb: done, errors");
		$finish;
	end

	// Watchdog: ends the run with an error report if it hangs
	initial begin
		#20_000_000;
		$display("bracket_balance_checker_unit_tb: done, errors");
		$finish;
	end

endmodule
